// ===== hdl/ternary_vector_clique_dictionary_top_defines.svh =====
`ifndef TERNARY_VECTOR_CLIQUE_DICTIONARY_TOP_DEFINES_SVH
`define TERNARY_VECTOR_CLIQUE_DICTIONARY_TOP_DEFINES_SVH

// same-cycle implication
`define TVCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvcd assertion failed");

// next-cycle implication
`define TVCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvcd assertion failed");

`endif

// ===== hdl/tvcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tvcd_pkg;

  localparam int unsigned RESULT_CAP = 64;
  localparam int unsigned CAP_W = 6;
  localparam int unsigned ENT_W = 7;
  localparam logic [ENT_W-1:0] MAX_ENTRIES_RST = 7'd16;

  typedef enum logic [3:0] {
    S_LOAD,
    S_LIVE,
    S_PICK,
    S_GROW,
    S_MERGE,
    S_STORE,
    S_EMIT_RD,
    S_EMIT,
    S_EMPTY
  } state_t;

  typedef struct packed {
    logic acc_clr;
    logic acc_or;
  } acc_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/tvcd_vec_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tvcd_vec_if #(
  parameter int W = 32
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] care_bits;
  logic [W-1:0] value_bits;
  logic         last_vector;

  modport source(output valid, care_bits, value_bits, last_vector, input ready);
  modport sink(input valid, care_bits, value_bits, last_vector, output ready);
endinterface

`default_nettype wire

// ===== hdl/tvcd_entry_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tvcd_entry_if #(
  parameter int W = 32
) ();
  logic         valid;
  logic         ready;
  logic         entry_valid;
  logic [W-1:0] entry_care;
  logic [W-1:0] entry_value;
  logic         entry_last;
  logic         short_dictionary;
  logic         vectors_dropped;

  modport source(output valid, entry_valid, entry_care, entry_value, entry_last,
                 short_dictionary, vectors_dropped, input ready);
  modport sink(input valid, entry_valid, entry_care, entry_value, entry_last,
               short_dictionary, vectors_dropped, output ready);
endinterface

`default_nettype wire

// ===== hdl/tvcd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tvcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/tvcd_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tvcd_match #(
  parameter int W = 32
) (
  input  wire logic                clk,
  input  wire tvcd_pkg::acc_ctrl_t ctrl,
  input  wire logic [W-1:0]        a_care,
  input  wire logic [W-1:0]        a_val,
  input  wire logic [W-1:0]        b_care,
  input  wire logic [W-1:0]        b_val,
  output logic                     compat,
  output logic      [W-1:0]        acc_care,
  output logic      [W-1:0]        acc_val
);
  import tvcd_pkg::*;

  // no position cared by both with differing values
  assign compat = ~|(a_care & b_care & (a_val ^ b_val));

  // clique members never clash, so the merge is a plain or
  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc_care <= '0;
      acc_val  <= '0;
    end else if (ctrl.acc_or) begin
      acc_care <= acc_care | a_care;
      acc_val  <= acc_val | a_val;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ternary_vector_clique_dictionary_top.sv =====
// channel   | dir | payload                                        | role
// vec_in    | in  | care_bits, value_bits, last_vector             | ternary vectors
// entry_out | out | entry_valid/care/value/last, short, dropped    | dictionary entries
// cfg       | in  | cfg_we, cfg_data                               | max_entries
// loading takes one vector per cycle; ready drops after the last vector
// build: live marking, then per round a pick pass, a grow pass, a merge pass and a store,
//   all compares through one compatibility unit fed by two copies of the
//   vector store; live bit and round tag sit in two copies of a flag store
// emit: each entry is read from the entry buffer (S_EMIT_RD, then S_EMIT), held while entry_out.ready is low
// reset clears control at once; no store needs clearing, live marking rewrites each flag
`timescale 1ns / 1ps
`default_nettype none
`include "ternary_vector_clique_dictionary_top_defines.svh"

module ternary_vector_clique_dictionary_top #(
  parameter int VEC_LEN     = 32,
  parameter int MAX_VECTORS = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  tvcd_vec_if.sink                         vec_in,
  tvcd_entry_if.source                     entry_out,
  input  wire logic                        cfg_we,
  input  wire logic [tvcd_pkg::ENT_W-1:0]  cfg_data
);
  import tvcd_pkg::*;

  localparam int IW = $clog2(MAX_VECTORS);
  localparam int CW = $clog2(MAX_VECTORS + 1);
  localparam int VW = 2 * VEC_LEN;

  state_t                 state, state_next;
  logic [IW-1:0]          ca, ca_next, cb, cb_next;
  logic                   phase, phase_next;
  logic [CW-1:0]          vcount, vcount_next;
  logic                   overflow, overflow_next;
  logic [ENT_W-1:0]       entries_made, entries_made_next;
  logic [ENT_W-1:0]       max_entries;
  logic                   found, found_next, ok, ok_next;
  logic [CW-1:0]          best, best_next, deg, deg_next, d;
  logic [IW-1:0]          pick, pick_next;
  logic [CAP_W-1:0]       ek, ek_next;

  logic               ovld, ovld_next;
  logic               o_valid, o_valid_next, o_last, o_last_next;
  logic               o_short, o_short_next, o_drop, o_drop_next;
  logic [VEC_LEN-1:0] o_care, o_care_next, o_value, o_value_next;

  logic [ENT_W-1:0] limit;
  logic [ENT_W-1:0] round;
  logic [CW-1:0]    cnt_m1;
  logic             a_last, b_last, in_xfer, store_we, compat, ok_n, any_c;
  logic             round_end, pick_done, finish;
  logic [VW-1:0]    rd_a, rd_b, ent_rd;
  logic [VEC_LEN-1:0] acc_care, acc_val;
  acc_ctrl_t        acc_ctrl;
  logic [ENT_W:0]   fa, fb, fl_wdata;
  logic [IW-1:0]    fl_waddr;
  logic             fl_we, live_a, live_b, member_a;

  assign limit   = (max_entries > ENT_W'(RESULT_CAP)) ? ENT_W'(RESULT_CAP) : max_entries;
  assign round   = entries_made + 1'b1;
  assign cnt_m1  = vcount - 1'b1;
  assign a_last  = (CW'(ca) == cnt_m1);
  assign b_last  = (CW'(cb) == cnt_m1);
  assign in_xfer = vec_in.valid & vec_in.ready;
  assign store_we = in_xfer & (vcount < CW'(MAX_VECTORS));
  assign vec_in.ready = (state == S_LOAD);

  // flag word: live bit over the round tag of the clique it joined
  assign live_a   = fa[ENT_W];
  assign live_b   = fb[ENT_W];
  assign member_a = (fa[ENT_W-1:0] == round);

  tvcd_ram #(.WIDTH(VW), .DEPTH(MAX_VECTORS)) u_store_a (
    .clk   (clk),
    .we    (store_we),
    .waddr (vcount[IW-1:0]),
    .wdata ({vec_in.care_bits, vec_in.value_bits & vec_in.care_bits}),
    .raddr (ca),
    .rdata (rd_a)
  );

  tvcd_ram #(.WIDTH(VW), .DEPTH(MAX_VECTORS)) u_store_b (
    .clk   (clk),
    .we    (store_we),
    .waddr (vcount[IW-1:0]),
    .wdata ({vec_in.care_bits, vec_in.value_bits & vec_in.care_bits}),
    .raddr (cb),
    .rdata (rd_b)
  );

  tvcd_ram #(.WIDTH(ENT_W + 1), .DEPTH(MAX_VECTORS)) u_flag_a (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (ca),
    .rdata (fa)
  );

  tvcd_ram #(.WIDTH(ENT_W + 1), .DEPTH(MAX_VECTORS)) u_flag_b (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (cb),
    .rdata (fb)
  );

  tvcd_ram #(.WIDTH(VW), .DEPTH(RESULT_CAP)) u_entries (
    .clk   (clk),
    .we    (state == S_STORE),
    .waddr (entries_made[CAP_W-1:0]),
    .wdata ({acc_care, acc_val}),
    .raddr (ek),
    .rdata (ent_rd)
  );

  tvcd_match #(.W(VEC_LEN)) u_match (
    .clk      (clk),
    .ctrl     (acc_ctrl),
    .a_care   (rd_a[VW-1:VEC_LEN]),
    .a_val    (rd_a[VEC_LEN-1:0]),
    .b_care   (rd_b[VW-1:VEC_LEN]),
    .b_val    (rd_b[VEC_LEN-1:0]),
    .compat   (compat),
    .acc_care (acc_care),
    .acc_val  (acc_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 1'b0;
      vcount       <= '0;
      overflow     <= 1'b0;
      entries_made <= '0;
      max_entries  <= MAX_ENTRIES_RST;
      ovld         <= 1'b0;
    end else begin
      phase        <= phase_next;
      vcount       <= vcount_next;
      overflow     <= overflow_next;
      entries_made <= entries_made_next;
      ovld         <= ovld_next;
      if (cfg_we) begin
        max_entries <= cfg_data;
      end
    end
    ca      <= ca_next;
    cb      <= cb_next;
    found   <= found_next;
    ok      <= ok_next;
    best    <= best_next;
    deg     <= deg_next;
    pick    <= pick_next;
    ek      <= ek_next;
    o_valid <= o_valid_next;
    o_last  <= o_last_next;
    o_short <= o_short_next;
    o_drop  <= o_drop_next;
    o_care  <= o_care_next;
    o_value <= o_value_next;
  end

  always_comb begin
    state_next        = state;
    ca_next           = ca;
    cb_next           = cb;
    phase_next        = phase;
    vcount_next       = vcount;
    overflow_next     = overflow;
    entries_made_next = entries_made;
    found_next        = found;
    ok_next           = ok;
    best_next         = best;
    deg_next          = deg;
    pick_next         = pick;
    ek_next           = ek;
    ovld_next         = ovld & ~entry_out.ready;
    o_valid_next      = o_valid;
    o_last_next       = o_last;
    o_short_next      = o_short;
    o_drop_next       = o_drop;
    o_care_next       = o_care;
    o_value_next      = o_value;
    acc_ctrl          = '0;
    round_end         = 1'b0;
    pick_done         = 1'b0;
    finish            = 1'b0;
    fl_we             = 1'b0;
    fl_waddr          = ca;
    fl_wdata          = '0;
    d                 = deg;
    ok_n              = ok & (~member_a | compat);
    any_c             = ok | ((ca != cb) & compat);

    case (state)
      S_LOAD: begin
        if (in_xfer) begin
          if (vcount < CW'(MAX_VECTORS)) begin
            vcount_next = vcount + 1'b1;
          end else begin
            overflow_next = 1'b1;
          end
          if (vec_in.last_vector) begin
            entries_made_next = '0;
            ca_next    = '0;
            cb_next    = '0;
            ok_next    = 1'b0;
            phase_next = 1'b0;
            state_next = S_LIVE;
          end
        end
      end
      S_LIVE: begin
        if (!phase) begin
          phase_next = 1'b1;
        end else begin
          phase_next = 1'b0;
          if (b_last) begin
            fl_we    = 1'b1;
            fl_waddr = ca;
            fl_wdata = {any_c, ENT_W'(0)};
            ok_next  = 1'b0;
            cb_next  = '0;
            if (a_last) begin
              round_end = 1'b1;
            end else begin
              ca_next = ca + 1'b1;
            end
          end else begin
            ok_next = any_c;
            cb_next = cb + 1'b1;
          end
        end
      end
      S_PICK: begin
        if (!phase) begin
          phase_next = 1'b1;
        end else begin
          phase_next = 1'b0;
          if (!live_a) begin
            cb_next  = '0;
            deg_next = '0;
            if (a_last) begin
              pick_done = 1'b1;
            end else begin
              ca_next = ca + 1'b1;
            end
          end else begin
            d = deg + CW'(ca != cb && live_b && compat);
            if (b_last) begin
              cb_next  = '0;
              deg_next = '0;
              if (!found || d > best) begin
                found_next = 1'b1;
                best_next  = d;
                pick_next  = ca;
              end
              if (a_last) begin
                pick_done = 1'b1;
              end else begin
                ca_next = ca + 1'b1;
              end
            end else begin
              deg_next = d;
              cb_next  = cb + 1'b1;
            end
          end
        end
      end
      S_GROW: begin
        if (!phase) begin
          phase_next = 1'b1;
        end else begin
          phase_next = 1'b0;
          if (cb == pick || !live_b) begin
            if (b_last) begin
              state_next = S_MERGE;
              ca_next    = '0;
              acc_ctrl.acc_clr = 1'b1;
            end else begin
              cb_next = cb + 1'b1;
            end
          end else if (a_last) begin
            fl_we    = 1'b1;
            fl_waddr = cb;
            fl_wdata = {1'b1, ok_n ? round : ENT_W'(0)};
            ok_next  = 1'b1;
            ca_next  = '0;
            if (b_last) begin
              state_next = S_MERGE;
              acc_ctrl.acc_clr = 1'b1;
            end else begin
              cb_next = cb + 1'b1;
            end
          end else begin
            ok_next = ok_n;
            ca_next = ca + 1'b1;
          end
        end
      end
      S_MERGE: begin
        if (!phase) begin
          phase_next = 1'b1;
        end else begin
          phase_next = 1'b0;
          if (member_a) begin
            acc_ctrl.acc_or = 1'b1;
            fl_we    = 1'b1;
            fl_waddr = ca;
            fl_wdata = {1'b0, fa[ENT_W-1:0]};
          end
          if (a_last) begin
            state_next = S_STORE;
          end else begin
            ca_next = ca + 1'b1;
          end
        end
      end
      S_STORE: begin
        entries_made_next = entries_made + 1'b1;
        round_end = 1'b1;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!ovld || entry_out.ready) begin
          ovld_next    = 1'b1;
          o_valid_next = 1'b1;
          o_care_next  = ent_rd[VW-1:VEC_LEN];
          o_value_next = ent_rd[VEC_LEN-1:0];
          o_last_next  = (ENT_W'(ek) + 1'b1 == entries_made);
          o_short_next = (entries_made < limit);
          o_drop_next  = overflow;
          if (ENT_W'(ek) + 1'b1 == entries_made) begin
            state_next    = S_LOAD;
            vcount_next   = '0;
            overflow_next = 1'b0;
          end else begin
            ek_next    = ek + 1'b1;
            state_next = S_EMIT_RD;
          end
        end
      end
      S_EMPTY: begin
        if (!ovld || entry_out.ready) begin
          ovld_next     = 1'b1;
          o_valid_next  = 1'b0;
          o_care_next   = '0;
          o_value_next  = '0;
          o_last_next   = 1'b1;
          o_short_next  = (entries_made < limit);
          o_drop_next   = overflow;
          state_next    = S_LOAD;
          vcount_next   = '0;
          overflow_next = 1'b0;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase

    if (round_end) begin
      if (entries_made_next < limit) begin
        state_next = S_PICK;
        ca_next    = '0;
        cb_next    = '0;
        phase_next = 1'b0;
        found_next = 1'b0;
        best_next  = '0;
        deg_next   = '0;
      end else begin
        finish = 1'b1;
      end
    end

    if (pick_done) begin
      if (found_next) begin
        state_next = S_GROW;
        fl_we      = 1'b1;
        fl_waddr   = pick_next;
        fl_wdata   = {1'b1, round};
        ca_next    = '0;
        cb_next    = '0;
        ok_next    = 1'b1;
        phase_next = 1'b0;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      ek_next    = '0;
      state_next = (entries_made_next == '0) ? S_EMPTY : S_EMIT_RD;
    end
  end

  assign entry_out.valid            = ovld;
  assign entry_out.entry_valid      = o_valid;
  assign entry_out.entry_care       = o_care;
  assign entry_out.entry_value      = o_value;
  assign entry_out.entry_last       = o_last;
  assign entry_out.short_dictionary = o_short;
  assign entry_out.vectors_dropped  = o_drop;

  `TVCD_ASSERT_IMP(a_empty_last, clk, rst, entry_out.valid && !entry_out.entry_valid, entry_out.entry_last)
  `TVCD_ASSERT_NXT(a_out_hold, clk, rst, entry_out.valid && !entry_out.ready, entry_out.valid)
  `TVCD_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, vcount <= CW'(MAX_VECTORS))
  `TVCD_ASSERT_NXT(a_store_limit, clk, rst, state == S_STORE, entries_made <= limit)

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import tvcd_pkg::*;

  typedef struct {
    logic        present;
    logic [31:0] care;
    logic [31:0] value;
    logic        last;
    logic        short_dict;
    logic        dropped;
  } dict_entry_t;

  class dictionary_scoreboard;
    logic [31:0] care_mem[256];
    logic [31:0] value_mem[256];
    bit          live[256];
    bit          member[256];
    int unsigned stored;
    bit          overflow;
    int unsigned entry_limit;
    dict_entry_t pending[$];
    int          errors;

    function new();
      stored = 0;
      overflow = 0;
      entry_limit = 16;
      errors = 0;
    endfunction

    function bit agree(int unsigned a, int unsigned b);
      return (care_mem[a] & care_mem[b] & (value_mem[a] ^ value_mem[b])) == 0;
    endfunction

    function int unsigned degree(int unsigned v);
      int unsigned d;
      d = 0;
      for (int unsigned j = 0; j < stored; j++)
        if (j != v && live[j] && agree(v, j)) d++;
      return d;
    endfunction

    function bit fits(int unsigned c);
      for (int unsigned m = 0; m < stored; m++)
        if (member[m] && !agree(m, c)) return 0;
      return 1;
    endfunction

    function void note_vector(logic [31:0] care, logic [31:0] value, logic last);
      int unsigned cap;
      int unsigned made;
      int unsigned pick;
      int unsigned best;
      int unsigned d;
      bit found;
      logic [31:0] mc, mv, take, clash;
      logic [31:0] ec[64];
      logic [31:0] ev[64];
      dict_entry_t e;
      if (stored < 256) begin
        care_mem[stored] = care;
        value_mem[stored] = value & care;
        stored++;
      end else begin
        overflow = 1;
      end
      if (!last) return;
      cap = (entry_limit > 64) ? 64 : entry_limit;
      for (int unsigned i = 0; i < stored; i++) begin
        live[i] = 0;
        member[i] = 0;
        for (int unsigned j = 0; j < stored; j++)
          if (j != i && agree(i, j)) begin
            live[i] = 1;
            break;
          end
      end
      made = 0;
      while (made < cap) begin
        found = 0;
        pick = 0;
        best = 0;
        for (int unsigned i = 0; i < stored; i++) begin
          if (!live[i]) continue;
          d = degree(i);
          if (!found || d > best) begin
            found = 1;
            best = d;
            pick = i;
          end
        end
        if (!found) break;
        for (int unsigned j = 0; j < 256; j++) member[j] = 0;
        member[pick] = 1;
        for (int unsigned j = 0; j < stored; j++)
          if (j != pick && live[j] && agree(pick, j) && fits(j)) member[j] = 1;
        mc = care_mem[pick];
        mv = value_mem[pick];
        for (int unsigned j = 0; j < stored; j++) begin
          if (!member[j] || j == pick) continue;
          take = ~mc & care_mem[j];
          clash = mc & care_mem[j] & (mv ^ value_mem[j]);
          mc = (mc & ~clash) | take;
          mv = (mv & ~clash) | (value_mem[j] & take);
        end
        for (int unsigned j = 0; j < stored; j++)
          if (member[j]) live[j] = 0;
        ec[made] = mc;
        ev[made] = mv & mc;
        made++;
      end
      e.short_dict = made < cap;
      e.dropped = overflow;
      if (made == 0) begin
        e.present = 0;
        e.care = '0;
        e.value = '0;
        e.last = 1;
        pending.insert(pending.size(), e);
      end else begin
        for (int unsigned k = 0; k < made; k++) begin
          e.present = 1;
          e.care = ec[k];
          e.value = ev[k];
          e.last = (k + 1 == made);
          pending.insert(pending.size(), e);
        end
      end
      stored = 0;
      overflow = 0;
      for (int unsigned j = 0; j < 256; j++) begin
        live[j] = 0;
        member[j] = 0;
      end
    endfunction

    function void check_entry(dict_entry_t got);
      dict_entry_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected entry care=%h value=%h", $time, got.care, got.value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.present !== want.present) begin
        $display("%0t: entry_valid exp %b got %b", $time, want.present, got.present);
        errors++;
      end
      if (got.care !== want.care) begin
        $display("%0t: entry_care exp %h got %h", $time, want.care, got.care);
        errors++;
      end
      if (got.value !== want.value) begin
        $display("%0t: entry_value exp %h got %h", $time, want.value, got.value);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: entry_last exp %b got %b", $time, want.last, got.last);
        errors++;
      end
      if (got.short_dict !== want.short_dict) begin
        $display("%0t: short_dictionary exp %b got %b", $time, want.short_dict,
                 got.short_dict);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $display("%0t: vectors_dropped exp %b got %b", $time, want.dropped, got.dropped);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [ENT_W-1:0]     cfg_data;
  tvcd_vec_if   #(.W(32)) vec_ch ();
  tvcd_entry_if #(.W(32)) entry_ch ();

  ternary_vector_clique_dictionary_top #(
    .VEC_LEN(32),
    .MAX_VECTORS(256)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .vec_in(vec_ch.sink),
    .entry_out(entry_ch.source),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  dictionary_scoreboard dict_sb;
  bit          quiet;
  int          hold_request;
  int          hold_left;
  int          stall_left;
  int unsigned idle_cycles;
  int unsigned vectors_sent;
  logic [31:0] set_base;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    dict_sb = new();
    quiet = 0;
    hold_request = 0;
    rst = 1;
    cfg_we = 0;
    cfg_data = '0;
    vec_ch.valid = 0;
    vec_ch.care_bits = '0;
    vec_ch.value_bits = '0;
    vec_ch.last_vector = 0;
    entry_ch.ready = 0;
  end

  // result side: check transfers, random back-pressure
  always @(posedge clk) begin
    dict_entry_t got;
    if (rst) begin
      entry_ch.ready <= 0;
      hold_left = 0;
      stall_left = 0;
    end else begin
      if (entry_ch.valid && entry_ch.ready) begin
        got.present = entry_ch.entry_valid;
        got.care = entry_ch.entry_care;
        got.value = entry_ch.entry_value;
        got.last = entry_ch.entry_last;
        got.short_dict = entry_ch.short_dictionary;
        got.dropped = entry_ch.vectors_dropped;
        dict_sb.check_entry(got);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        entry_ch.ready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        entry_ch.ready <= 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        entry_ch.ready <= 0;
      end else begin
        entry_ch.ready <= 1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (vec_ch.valid && vec_ch.ready) || (entry_ch.valid && entry_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_vector(logic [31:0] care, logic [31:0] value, logic last);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      vec_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    vec_ch.valid <= 1;
    vec_ch.care_bits <= care;
    vec_ch.value_bits <= value;
    vec_ch.last_vector <= last;
    @(posedge clk);
    while (!vec_ch.ready) @(posedge clk);
    dict_sb.note_vector(care, value, last);
    vectors_sent++;
  endtask

  task automatic write_limit(logic [ENT_W-1:0] limit);
    vec_ch.valid <= 0;
    @(posedge clk);
    while (dict_sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 0;
    dict_sb.entry_limit = limit;
  endtask

  function automatic logic [31:0] rand_care();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom & $urandom & $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return set_base ^ ($urandom & $urandom & $urandom & $urandom);
  endfunction

  task automatic send_set(int size);
    set_base = $urandom;
    for (int i = 0; i < size; i++)
      send_vector(rand_care(), rand_value(), i == size - 1);
  endtask

  initial begin
    int set_size;
    vectors_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed sets
    write_limit(7'd64);
    send_vector('1, '0, 0);
    send_vector('1, '1, 1);
    send_vector('0, '1, 0);
    send_vector('1, 32'hAAAA_AAAA, 0);
    send_vector(32'h5555_5555, 32'hFFFF_0000, 1);
    send_vector('0, '0, 1);
    send_vector(32'hFFFF_0000, 32'h1234_5678, 0);
    send_vector(32'h0000_FFFF, 32'h8765_4321, 0);
    send_vector(32'hFFFF_0000, 32'h1234_0000, 1);
    write_limit(7'd0);
    send_vector('0, '0, 0);
    send_vector('0, '1, 1);
    write_limit(7'd1);
    send_vector(32'h0000_000F, 32'h5, 0);
    send_vector(32'h0000_00F0, 32'h50, 0);
    send_vector(32'h0000_000F, 32'hA, 0);
    send_vector(32'h0000_00F0, 32'hA0, 1);
    write_limit(7'd127);
    send_set(6);

    // capacity overflow with a small limit to keep the build short
    write_limit(7'd2);
    for (int i = 0; i < 258; i++)
      send_vector($urandom & $urandom, $urandom, i == 257);

    // long hold on the result side while the sender keeps going
    write_limit(7'd64);
    hold_request = 400;
    for (int s = 0; s < 4; s++) send_set($urandom_range(6, 10));

    while (vectors_sent < 470) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 3) == 0) write_limit(ENT_W'($urandom_range(0, 127)));
        else write_limit(ENT_W'($urandom_range(1, 12)));
      end
      if (vectors_sent > 420) quiet = 1;
      set_size = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 10);
      send_set(set_size);
    end

    vec_ch.valid <= 0;
    @(posedge clk);
    while (dict_sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (dict_sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
